FILE: rtl/fpc_pkg.sv
// Shared types, codes and helpers for the fixed-point calculator ALU.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
`default_nettype none
package fpc_pkg;

    localparam int ANG_BITS = 24;
    localparam int QUO_W    = 32;

    localparam logic [3:0] OP_MUL   = 4'd0;
    localparam logic [3:0] OP_DIV   = 4'd1;
    localparam logic [3:0] OP_ADD   = 4'd2;
    localparam logic [3:0] OP_SUB   = 4'd3;
    localparam logic [3:0] OP_AVG   = 4'd4;
    localparam logic [3:0] OP_ABS   = 4'd5;
    localparam logic [3:0] OP_F2C   = 4'd6;
    localparam logic [3:0] OP_C2F   = 4'd7;
    localparam logic [3:0] OP_TAN   = 4'd8;
    localparam logic [3:0] OP_ROUND = 4'd9;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [3:0]          func;
        logic signed [31:0]  a;
        logic signed [31:0]  b;
        logic signed [63:0]  prod;
        logic [31:0]         res;
        logic [1:0]          st;
        logic                use_div;
        logic [63:0]         dvd;
        logic [31:0]         dvs;
        logic                neg;
        logic signed [31:0]  post;
        logic                ovf;
        logic [QUO_W-1:0]    quo;
        logic [32:0]         ang;
        logic                ang_neg;
        logic signed [31:0]  r;
        logic signed [33:0]  x;
        logic signed [33:0]  y;
        logic signed [32:0]  z;
    } pipe_t;

    typedef struct packed {
        logic [31:0] val;
        logic [1:0]  st;
    } sat_t;

    function automatic sat_t sat64(input logic signed [63:0] v);
        sat_t o;
        o.st = ST_OK;
        if (v > 64'sd2147483647)
        begin
            o.val = Q_MAX;
            o.st  = ST_SAT;
        end
        else if (v < -64'sd2147483648)
        begin
            o.val = Q_MIN;
            o.st  = ST_SAT;
        end
        else
        begin
            o.val = v[31:0];
        end
        return o;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        logic signed [63:0] n;
        n = -v;
        return v[63] ? n : v;
    endfunction

    // arctangent of 2^-i in degrees, 24 fraction bits
    function automatic logic [31:0] atan_deg(input int idx);
        logic [31:0] t;
        unique case (idx)
            0:  t = 32'd754974720;
            1:  t = 32'd445687602;
            2:  t = 32'd235489088;
            3:  t = 32'd119537938;
            4:  t = 32'd60000934;
            5:  t = 32'd30029717;
            6:  t = 32'd15018523;
            7:  t = 32'd7509720;
            8:  t = 32'd3754917;
            9:  t = 32'd1877466;
            10: t = 32'd938734;
            11: t = 32'd469367;
            12: t = 32'd234684;
            13: t = 32'd117342;
            14: t = 32'd58671;
            15: t = 32'd29335;
            16: t = 32'd14668;
            17: t = 32'd7334;
            18: t = 32'd3667;
            19: t = 32'd1833;
            20: t = 32'd917;
            21: t = 32'd458;
            22: t = 32'd229;
            23: t = 32'd115;
            default: t = 32'd0;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/fpc_front.sv
// Decode stage: finishes the short operations and sets up divider and angle work.
// Depends on fpc_pkg.
`default_nettype none
module fpc_front #(
    parameter int FRAC_BITS = 16
) (
    input  fpc_pkg::pipe_t d,
    output fpc_pkg::pipe_t q
);

    localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [63:0] KEEP     = ~((64'sd1 <<< FRAC_BITS) - 64'sd1);
    localparam logic signed [63:0] OFS32    = 64'sd32 <<< FRAC_BITS;

    logic signed [63:0] a64;
    logic signed [63:0] b64;
    logic signed [63:0] sum64;
    logic signed [63:0] avg64;
    logic signed [63:0] rv;
    logic signed [63:0] rt;
    logic signed [63:0] f2c_t;
    logic signed [63:0] c2f_t;
    logic [63:0]        amag;
    logic [63:0]        bmag;
    fpc_pkg::sat_t      sv;

    assign a64   = 64'(d.a);
    assign b64   = 64'(d.b);
    assign sum64 = a64 + b64;
    assign avg64 = sum64[63] ? ((sum64 + 64'sd1) >>> 1) : (sum64 >>> 1);
    assign rv    = a64 + HALF_LSB;
    assign rt    = rv[63] ? -((-rv) & KEEP) : (rv & KEEP);
    assign f2c_t = (a64 - OFS32) * 64'sd5;
    assign c2f_t = a64 * 64'sd9;
    assign amag  = fpc_pkg::mag64(a64);
    assign bmag  = fpc_pkg::mag64(b64);

    always_comb
    begin
        q         = d;
        q.res     = '0;
        q.st      = fpc_pkg::ST_OK;
        q.use_div = 1'b0;
        q.dvd     = '0;
        q.dvs     = 32'd1;
        q.neg     = 1'b0;
        q.post    = '0;
        q.ovf     = 1'b0;
        q.quo     = '0;
        q.ang     = amag[32:0];
        q.ang_neg = d.a[31];
        q.r       = '0;
        q.x       = 34'sd1 <<< 30;
        q.y       = '0;
        q.z       = '0;
        sv        = '0;
        unique case (d.func)
            fpc_pkg::OP_MUL:   sv = fpc_pkg::sat64(d.prod >>> FRAC_BITS);
            fpc_pkg::OP_ADD:   sv = fpc_pkg::sat64(sum64);
            fpc_pkg::OP_SUB:   sv = fpc_pkg::sat64(a64 - b64);
            fpc_pkg::OP_AVG:   sv = fpc_pkg::sat64(avg64);
            fpc_pkg::OP_ABS:   sv = fpc_pkg::sat64(d.a[31] ? -a64 : a64);
            fpc_pkg::OP_ROUND: sv = fpc_pkg::sat64(rt);
            fpc_pkg::OP_DIV:
            begin
                if (d.b == 32'sd0)
                begin
                    sv.val = d.a;
                    sv.st  = fpc_pkg::ST_DIV0;
                end
                else
                begin
                    q.use_div = 1'b1;
                    q.dvd     = amag << FRAC_BITS;
                    q.dvs     = bmag[31:0];
                    q.neg     = d.a[31] ^ d.b[31];
                end
            end
            fpc_pkg::OP_F2C:
            begin
                q.use_div = 1'b1;
                q.dvd     = fpc_pkg::mag64(f2c_t);
                q.dvs     = 32'd9;
                q.neg     = f2c_t[63];
            end
            fpc_pkg::OP_C2F:
            begin
                q.use_div = 1'b1;
                q.dvd     = fpc_pkg::mag64(c2f_t);
                q.dvs     = 32'd5;
                q.neg     = c2f_t[63];
                q.post    = 32'(OFS32);
            end
            fpc_pkg::OP_TAN:   q.use_div = 1'b1;
            default:           sv = '0;
        endcase
        q.res = sv.val;
        q.st  = sv.st;
    end

endmodule
`default_nettype wire

FILE: rtl/fpc_red_stage.sv
// One step of the angle reduction modulo 180 degrees: drop a shifted period.
// Depends on fpc_pkg.
`default_nettype none
module fpc_red_stage #(
    parameter int FRAC_BITS = 16,
    parameter int SHIFT     = 0
) (
    input  fpc_pkg::pipe_t d,
    output fpc_pkg::pipe_t q
);

    localparam logic [39:0] STEP = 40'd180 << (FRAC_BITS + SHIFT);

    logic [39:0] ang40;
    logic [39:0] diff;

    assign ang40 = {7'b0, d.ang};
    assign diff  = ang40 - STEP;

    always_comb
    begin
        q = d;
        if (ang40 >= STEP)
        begin
            q.ang = diff[32:0];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/fpc_cordic_stage.sv
// One rotation-mode CORDIC iteration in degrees.
// Depends on fpc_pkg.
`default_nettype none
module fpc_cordic_stage #(
    parameter int IDX = 0
) (
    input  fpc_pkg::pipe_t d,
    output fpc_pkg::pipe_t q
);

    localparam logic [31:0]        ATAN_U = fpc_pkg::atan_deg(IDX);
    localparam logic signed [32:0] ATAN   = $signed({1'b0, ATAN_U});

    logic signed [33:0] xs;
    logic signed [33:0] ys;

    assign xs = d.x >>> IDX;
    assign ys = d.y >>> IDX;

    always_comb
    begin
        q = d;
        if (!d.z[32])
        begin
            q.x = d.x - ys;
            q.y = d.y + xs;
            q.z = d.z - ATAN;
        end
        else
        begin
            q.x = d.x + ys;
            q.y = d.y - xs;
            q.z = d.z + ATAN;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/fpc_div_stage.sv
// One restoring-division step: resolve quotient bit BIT.
// Depends on fpc_pkg.
`default_nettype none
module fpc_div_stage #(
    parameter int BIT = 0
) (
    input  fpc_pkg::pipe_t d,
    output fpc_pkg::pipe_t q
);

    logic [63:0] sh;

    assign sh = {32'b0, d.dvs} << BIT;

    always_comb
    begin
        q = d;
        if (d.dvd >= sh)
        begin
            q.dvd      = d.dvd - sh;
            q.quo[BIT] = 1'b1;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/fixed_point_calculator_alu_unit.sv
// Each beat passes decode, the angle reduction and CORDIC chains and the
// 32 quotient steps on its way from start to done.
// Throughput: one beat per cycle; busy stays low, results come out in order.
// Reset: rst_n clears every stage valid bit and done; data registers hold junk.
// The receiver cannot stall: each result shows for one cycle with done high.
// Depends on fpc_pkg, fpc_front, fpc_red_stage, fpc_cordic_stage, fpc_div_stage.
`default_nettype none
module fixed_point_calculator_alu_unit #(
    parameter int FRAC_BITS = 16,
    parameter int TAN_STEPS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [3:0]         func,
    input  wire logic signed [31:0] operand_a,
    input  wire logic signed [31:0] operand_b,
    output logic                    done,
    output logic signed [31:0]      result,
    output logic [1:0]              status
);

    // Stage map: input latch with multiply, decode, angle reduction steps,
    // angle fold, CORDIC steps, tangent divide setup, overflow check,
    // then one stage per quotient bit.
    localparam int RED_STEPS = 25 - FRAC_BITS;
    localparam int S_FRONT   = 1;
    localparam int S_RED0    = 2;
    localparam int S_FOLD    = S_RED0 + RED_STEPS;
    localparam int S_COR0    = S_FOLD + 1;
    localparam int S_TDIV    = S_COR0 + TAN_STEPS;
    localparam int S_OVF     = S_TDIV + 1;
    localparam int S_DIV0    = S_OVF + 1;
    localparam int N_STG     = S_DIV0 + fpc_pkg::QUO_W;

    localparam logic [32:0] PERIOD   = 33'd180 << FRAC_BITS;
    localparam logic [32:0] HALF_ANG = 33'd90 << FRAC_BITS;
    localparam int          Z_SHIFT  = fpc_pkg::ANG_BITS - FRAC_BITS;

    fpc_pkg::pipe_t     stg_reg  [N_STG];
    fpc_pkg::pipe_t     stg_next [N_STG];
    logic [N_STG-1:0]   vld_reg;

    fpc_pkg::pipe_t     in_item;
    fpc_pkg::pipe_t     fold_next;
    fpc_pkg::pipe_t     tdiv_next;
    fpc_pkg::pipe_t     ovf_next;
    fpc_pkg::pipe_t     fin;

    logic [32:0]        fold_r0;
    logic signed [33:0] fold_sr;
    logic signed [33:0] fold_z;
    logic [63:0]        ymag;
    logic signed [63:0] fin_q;
    logic signed [63:0] fin_v;
    fpc_pkg::sat_t      fin_sat;

    logic               done_reg;
    logic               done_next;
    logic [31:0]        result_reg;
    logic [31:0]        result_next;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;

    // The pipeline never pushes back.
    assign busy = 1'b0;

    // Latch the beat and start the multiply.
    always_comb
    begin
        in_item      = '0;
        in_item.func = func;
        in_item.a    = operand_a;
        in_item.b    = operand_b;
        in_item.prod = 64'(operand_a) * 64'(operand_b);
    end

    // Fold the reduced magnitude into (-90, 90] and scale to CORDIC angle.
    always_comb
    begin
        fold_next = stg_reg[S_FOLD-1];
        fold_r0   = (stg_reg[S_FOLD-1].ang_neg && stg_reg[S_FOLD-1].ang != '0)
                    ? PERIOD - stg_reg[S_FOLD-1].ang : stg_reg[S_FOLD-1].ang;
        fold_sr   = (fold_r0 > HALF_ANG)
                    ? $signed({1'b0, fold_r0}) - $signed({1'b0, PERIOD})
                    : $signed({1'b0, fold_r0});
        fold_z    = fold_sr <<< Z_SHIFT;
        if (stg_reg[S_FOLD-1].func == fpc_pkg::OP_TAN)
        begin
            fold_next.r = fold_sr[31:0];
            fold_next.z = fold_z[32:0];
            if (fold_r0 == HALF_ANG)
            begin
                // exactly 90 degrees: saturate high, skip the divide
                fold_next.res     = fpc_pkg::Q_MAX;
                fold_next.st      = fpc_pkg::ST_SAT;
                fold_next.use_div = 1'b0;
            end
        end
    end

    // Hand y / x to the divider, or saturate when x has collapsed.
    always_comb
    begin
        tdiv_next = stg_reg[S_TDIV-1];
        ymag      = fpc_pkg::mag64(64'(stg_reg[S_TDIV-1].y));
        if (stg_reg[S_TDIV-1].func == fpc_pkg::OP_TAN && stg_reg[S_TDIV-1].use_div)
        begin
            if (stg_reg[S_TDIV-1].x <= 34'sd0)
            begin
                tdiv_next.res     = stg_reg[S_TDIV-1].r[31] ? fpc_pkg::Q_MIN
                                                             : fpc_pkg::Q_MAX;
                tdiv_next.st      = fpc_pkg::ST_SAT;
                tdiv_next.use_div = 1'b0;
            end
            else
            begin
                tdiv_next.dvd  = ymag << FRAC_BITS;
                tdiv_next.dvs  = stg_reg[S_TDIV-1].x[31:0];
                tdiv_next.neg  = stg_reg[S_TDIV-1].y[33];
                tdiv_next.post = '0;
            end
        end
    end

    // Flag quotients of 2^32 or more before the bit steps.
    always_comb
    begin
        ovf_next     = stg_reg[S_OVF-1];
        ovf_next.ovf = stg_reg[S_OVF-1].dvd >= {stg_reg[S_OVF-1].dvs, 32'b0};
    end

    genvar s;
    generate
        for (s = 0; s < N_STG; s++)
        begin : g_stg
            if (s == 0)
            begin : g_in
                assign stg_next[s] = in_item;
            end
            else if (s == S_FRONT)
            begin : g_front
                fpc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
                    .d (stg_reg[s-1]),
                    .q (stg_next[s])
                );
            end
            else if (s < S_FOLD)
            begin : g_red
                fpc_red_stage #(
                    .FRAC_BITS (FRAC_BITS),
                    .SHIFT     (RED_STEPS - 1 - (s - S_RED0))
                ) u_red (
                    .d (stg_reg[s-1]),
                    .q (stg_next[s])
                );
            end
            else if (s == S_FOLD)
            begin : g_fold
                assign stg_next[s] = fold_next;
            end
            else if (s < S_TDIV)
            begin : g_cor
                fpc_cordic_stage #(.IDX(s - S_COR0)) u_cor (
                    .d (stg_reg[s-1]),
                    .q (stg_next[s])
                );
            end
            else if (s == S_TDIV)
            begin : g_tdiv
                assign stg_next[s] = tdiv_next;
            end
            else if (s == S_OVF)
            begin : g_ovf
                assign stg_next[s] = ovf_next;
            end
            else
            begin : g_div
                fpc_div_stage #(.BIT(fpc_pkg::QUO_W - 1 - (s - S_DIV0))) u_div (
                    .d (stg_reg[s-1]),
                    .q (stg_next[s])
                );
            end

            // payload advances every cycle; only the valid bit is reset
            always_ff @(posedge clk)
            begin
                stg_reg[s] <= stg_next[s];
            end
        end
    endgenerate

    // Advance the valid bits alongside the payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[N_STG-2:0], start && !busy};
    end

    // Apply sign, offset and saturation to the quotient, or pass the early result.
    always_comb
    begin
        fin         = stg_reg[N_STG-1];
        fin_q       = $signed({32'b0, fin.quo});
        fin_v       = (fin.neg ? -fin_q : fin_q) + 64'(fin.post);
        fin_sat     = fpc_pkg::sat64(fin_v);
        done_next   = vld_reg[N_STG-1];
        result_next = fin.res;
        status_next = fin.st;
        if (fin.use_div)
        begin
            if (fin.ovf)
            begin
                result_next = fin.neg ? fpc_pkg::Q_MIN : fpc_pkg::Q_MAX;
                status_next = fpc_pkg::ST_SAT;
            end
            else
            begin
                result_next = fin_sat.val;
                status_next = fin_sat.st;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        status_reg <= status_next;
    end

    assign done   = done_reg;
    assign result = result_reg;
    assign status = status_reg;

    // A status code of three is never produced.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status != 2'd3))
        else $error("status code out of range");

    // Every accepted beat comes out after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(N_STG + 1) done)
        else $error("result missing at fixed latency");

    // No result without a beat at the matching input edge.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[0] == 1'b0) |-> ##N_STG (done == 1'b0))
        else $error("result without an accepted beat");

endmodule
`default_nettype wire

FILE: tb/tb_fixed_point_calculator_alu_unit.sv
// Self-checking testbench for the fixed-point calculator ALU unit.
// Predicts each result in SystemVerilog and compares it beat by beat.
// Depends on rtl/fpc_pkg.sv and rtl/fixed_point_calculator_alu_unit.sv.
`timescale 1ns / 100ps
module tb_fixed_point_calculator_alu_unit;
    import fpc_pkg::*;

    localparam int FRAC  = 16;
    localparam int STEPS = 16;
    localparam int N_RANDOM = 1930;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC;

    // Arctangent of 2^-i in degrees, 24 fraction bits.
    localparam logic signed [63:0] ATAN_DEG [0:23] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    typedef struct {
        logic [3:0]         func;
        logic signed [31:0] a;
        logic signed [31:0] b;
        int                 idle_pct;
    } calc_req_t;

    typedef struct {
        logic signed [31:0] val;
        logic [1:0]         st;
    } calc_out_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [3:0]         func;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic               done;
    logic signed [31:0] result;
    logic [1:0]         status;

    calc_req_t pending_reqs[$];
    calc_out_t expected_outs[$];
    int        err_count = 0;
    int        cycle_count = 0;

    fixed_point_calculator_alu_unit #(.FRAC_BITS(FRAC), .TAN_STEPS(STEPS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .done      (done),
        .result    (result),
        .status    (status)
    );

    // Clamp a wide value into Q range and flag saturation.
    function automatic calc_out_t clamp_q(input logic signed [63:0] v);
        calc_out_t o;
        o.st = ST_OK;
        if (v > 64'sd2147483647)
        begin
            o.val = Q_MAX;
            o.st  = ST_SAT;
        end
        else if (v < -64'sd2147483648)
        begin
            o.val = Q_MIN;
            o.st  = ST_SAT;
        end
        else
        begin
            o.val = v[31:0];
        end
        return o;
    endfunction

    // Tangent of an angle in degrees: reduce into (-90, 90], rotate, divide.
    function automatic calc_out_t tan_degrees(input logic signed [63:0] a);
        logic signed [63:0] period;
        logic signed [63:0] half;
        logic signed [63:0] r;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic signed [63:0] xs;
        logic signed [63:0] ys;
        calc_out_t o;
        period = 180 * ONE_Q;
        half   = 90 * ONE_Q;
        r = a % period;
        if (r < 0)
            r += period;
        if (r == half)
        begin
            o.val = Q_MAX;
            o.st  = ST_SAT;
            return o;
        end
        if (r > half)
            r -= period;
        z = r <<< (24 - FRAC);
        x = 64'sd1 <<< 30;
        y = 0;
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= ATAN_DEG[i];
            end
            else
            begin
                x += ys;
                y -= xs;
                z += ATAN_DEG[i];
            end
        end
        if (x <= 0)
        begin
            o.val = (r >= 0) ? Q_MAX : Q_MIN;
            o.st  = ST_SAT;
            return o;
        end
        return clamp_q((y * ONE_Q) / x);
    endfunction

    // Expected value and status for one request.
    function automatic calc_out_t calc_expected(input calc_req_t q);
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] v;
        logic signed [63:0] keep;
        calc_out_t o;
        a = q.a;
        b = q.b;
        o.val = '0;
        o.st  = ST_OK;
        case (q.func)
            OP_MUL: o = clamp_q((a * b) >>> FRAC);
            OP_DIV:
            begin
                if (b == 0)
                begin
                    o.val = q.a;
                    o.st  = ST_DIV0;
                end
                else
                begin
                    o = clamp_q((a * ONE_Q) / b);
                end
            end
            OP_ADD: o = clamp_q(a + b);
            OP_SUB: o = clamp_q(a - b);
            OP_AVG: o = clamp_q((a + b) / 2);
            OP_ABS: o = clamp_q(a < 0 ? -a : a);
            OP_F2C: o = clamp_q(((a - 32 * ONE_Q) * 5) / 9);
            OP_C2F: o = clamp_q((a * 9) / 5 + 32 * ONE_Q);
            OP_TAN: o = tan_degrees(a);
            OP_ROUND:
            begin
                // add one half, then drop the fraction toward zero
                v    = a + (64'sd1 <<< (FRAC - 1));
                keep = ~((64'sd1 <<< FRAC) - 1);
                v    = (v >= 0) ? (v & keep) : -((-v) & keep);
                o    = clamp_q(v);
            end
            default: ;
        endcase
        return o;
    endfunction

    // Operand mix: full range, small Q values, near-limit values, values near zero.
    function automatic logic signed [31:0] pick_operand();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2: return $urandom;
            3, 4, 5: return ($signed($urandom_range(0, 400)) - 200) * 65536
                            + $signed($urandom_range(0, 65535));
            6:       return Q_MAX - $urandom_range(0, 3);
            7:       return Q_MIN + $urandom_range(0, 3);
            8:       return $signed($urandom_range(0, 8)) - 4;
            default: return $signed($urandom_range(0, 1023)) - 512;
        endcase
    endfunction

    // Angles near the singular points of tangent, and general ones.
    function automatic logic signed [31:0] pick_angle();
        int k;
        k = $signed($urandom_range(0, 40)) - 20;
        if ($urandom_range(0, 1))
            return (90 + 180 * k) * 65536 + $signed($urandom_range(0, 64)) - 32;
        return pick_operand();
    endfunction

    task automatic add_req(input logic [3:0] f, input logic signed [31:0] a,
                           input logic signed [31:0] b, input int pct);
        calc_req_t q;
        q.func = f;
        q.a = a;
        q.b = b;
        q.idle_pct = pct;
        pending_reqs.push_back(q);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Driver: advance to the next pending beat after each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            func      <= OP_MUL;
            operand_a <= '0;
            operand_b <= '0;
        end
        else
        begin
            calc_req_t q;
            calc_req_t cur;
            bit        slot_free;
            slot_free = !start;
            if (start && !busy)
            begin
                cur.func = func;
                cur.a = operand_a;
                cur.b = operand_b;
                expected_outs.push_back(calc_expected(cur));
                slot_free = 1;
            end
            if (slot_free)
            begin
                if (pending_reqs.size() > 0 &&
                    $urandom_range(0, 99) >= pending_reqs[0].idle_pct)
                begin
                    q = pending_reqs.pop_front();
                    func      <= q.func;
                    operand_a <= q.a;
                    operand_b <= q.b;
                    start     <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every done beat must match the oldest expectation.
    always @(posedge clk)
    begin
        calc_out_t e;
        cycle_count <= cycle_count + 1;
        if (rst_n && done)
        begin
            if (expected_outs.size() == 0)
            begin
                $error("unexpected result beat: result=%0d status=%0d", result, status);
                err_count++;
            end
            else
            begin
                e = expected_outs.pop_front();
                if (result !== e.val)
                begin
                    $error("result: expected %0d, got %0d", e.val, result);
                    err_count++;
                end
                if (status !== e.st)
                begin
                    $error("status: expected %0d, got %0d", e.st, status);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: a hung block never gets to the end check.
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_fixed_point_calculator_alu_unit: done, errors");
            $finish;
        end
    end

    initial
    begin
        int pct;
        logic [3:0] f;
        rst_n = 1'b0;
        // directed beats: extremes, every operation, each corner case
        add_req(OP_MUL, Q_MAX, Q_MAX, 0);
        add_req(OP_MUL, Q_MIN, Q_MIN, 0);
        add_req(OP_MUL, -32'sd65536, -32'sd3, 0);
        add_req(OP_DIV, 32'sd12345, 32'sd0, 0);
        add_req(OP_DIV, Q_MIN, -32'sd1, 0);
        add_req(OP_DIV, -32'sd7, 32'sd3, 0);
        add_req(OP_ADD, Q_MAX, 32'sd1, 0);
        add_req(OP_SUB, Q_MIN, 32'sd1, 0);
        add_req(OP_AVG, Q_MAX, Q_MAX, 0);
        add_req(OP_AVG, Q_MIN, 32'sd1, 0);
        add_req(OP_ABS, Q_MIN, 32'sd0, 0);
        add_req(OP_ABS, -32'sd5, 32'sd0, 0);
        add_req(OP_F2C, 32'sd212 * 65536, 32'sd0, 0);
        add_req(OP_F2C, Q_MIN, 32'sd0, 0);
        add_req(OP_C2F, Q_MAX, 32'sd0, 0);
        add_req(OP_C2F, -32'sd40 * 65536, 32'sd0, 0);
        add_req(OP_TAN, 32'sd90 * 65536, 32'sd0, 0);
        add_req(OP_TAN, -32'sd90 * 65536, 32'sd0, 0);
        add_req(OP_TAN, 32'sd90 * 65536 - 1, 32'sd0, 0);
        add_req(OP_TAN, -32'sd89 * 65536 - 65535, 32'sd0, 0);
        add_req(OP_TAN, 32'sd45 * 65536, Q_MIN, 0);
        add_req(OP_ROUND, -32'sd98304, 32'sd0, 0);
        add_req(OP_ROUND, Q_MAX, 32'sd0, 0);
        add_req(OP_ROUND, Q_MIN, 32'sd0, 0);
        add_req(OP_ROUND + 4'd1, Q_MAX, Q_MIN, 0);
        // random beats in three idling phases: light, heavy, none
        for (int n = 0; n < N_RANDOM; n++)
        begin
            pct = (n < N_RANDOM / 3) ? 11 : (n < 2 * N_RANDOM / 3) ? 54 : 0;
            f = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(OP_ROUND + 1, 15))
                                              : 4'($urandom_range(OP_MUL, OP_ROUND));
            if (f == OP_TAN)
                add_req(f, pick_angle(), pick_operand(), pct);
            else
                add_req(f, pick_operand(), pick_operand(), pct);
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_reqs.size() == 0 && !start && expected_outs.size() == 0);
        repeat (100) @(posedge clk);
        if (err_count == 0 && expected_outs.size() == 0 && !start)
            $display("tb_fixed_point_calculator_alu_unit: done, clean");
        else
            $display("tb_fixed_point_calculator_alu_unit: done, errors");
        $finish;
    end

endmodule
